// ===== hw/rtl/mi3_pkg.sv =====
// Shared types, widths and cofactor index tables for the 3x3 inverse pipeline.
package mi3_pkg;

   // element format: signed fixed point, FRAC_W fraction bits
   localparam int ELEM_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int NUM_ELEM = 9;

   // datapath widths
   localparam int PROD_W  = 2 * ELEM_W;            // element * element
   localparam int COF_W   = 2 * ELEM_W + 1;        // cofactor, signed
   localparam int PART_W  = 2 * ELEM_W + 1;        // element * cofactor half
   localparam int TERM_W  = 3 * ELEM_W + 1;        // element * cofactor
   localparam int DET_W   = 3 * ELEM_W + 2;        // determinant, signed
   localparam int NMAG_W  = 2 * ELEM_W;            // |cofactor|
   localparam int DMAG_W  = 3 * ELEM_W + 1;        // |determinant|
   localparam int NUMER_W = NMAG_W + 2 * FRAC_W;   // scaled numerator
   localparam int CMP_W   = DMAG_W + ELEM_W + 1;   // divider compare width
   localparam int QUO_W   = ELEM_W;                // raw quotient bits
   localparam int RND_W   = ELEM_W + 1;            // rounded quotient

   // cofactor k = a[P]*a[Q] - a[S]*a[T]; row-major element index
   localparam int COF_P [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_Q [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_S [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_T [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   // first-row expansion: det = a0*cof0 + a1*cof3 + a2*cof6
   localparam int DET_COF [3] = '{0, 3, 6};

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a00;
      logic signed [ELEM_W-1:0] a01;
      logic signed [ELEM_W-1:0] a02;
      logic signed [ELEM_W-1:0] a10;
      logic signed [ELEM_W-1:0] a11;
      logic signed [ELEM_W-1:0] a12;
      logic signed [ELEM_W-1:0] a20;
      logic signed [ELEM_W-1:0] a21;
      logic signed [ELEM_W-1:0] a22;
   } mi3_req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] inv00;
      logic signed [ELEM_W-1:0] inv01;
      logic signed [ELEM_W-1:0] inv02;
      logic signed [ELEM_W-1:0] inv10;
      logic signed [ELEM_W-1:0] inv11;
      logic signed [ELEM_W-1:0] inv12;
      logic signed [ELEM_W-1:0] inv20;
      logic signed [ELEM_W-1:0] inv21;
      logic signed [ELEM_W-1:0] inv22;
      logic                     singular;
   } mi3_rsp_type;

   // control that rides along with each beat
   typedef struct packed {
      logic valid;
      logic singular;
   } mi3_ctl_type;

endpackage

// ===== hw/rtl/mi3_divider.sv =====
// Nine-lane pipelined restoring divider with rounding and saturation.
module mi3_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  mi3_pkg::mi3_ctl_type              in_ctl,
   input  logic [mi3_pkg::NMAG_W-1:0]        in_num [mi3_pkg::NUM_ELEM],
   input  logic                              in_neg [mi3_pkg::NUM_ELEM],
   input  logic [mi3_pkg::DMAG_W-1:0]        in_den,
   output mi3_pkg::mi3_ctl_type              out_ctl,
   output mi3_pkg::elem_type                 out_quo [mi3_pkg::NUM_ELEM]
);
   import mi3_pkg::*;

   localparam int NSTG = ELEM_W + 1;   // overflow check + one stage per bit
   localparam logic [RND_W-1:0] LIM = RND_W'(1) << (ELEM_W - 1);

   // per-stage state
   logic [NUMER_W-1:0] rem_ff [NSTG][NUM_ELEM];
   logic [QUO_W-1:0]   quo_ff [NSTG][NUM_ELEM];
   logic               ovf_ff [NSTG][NUM_ELEM];
   logic               neg_ff [NSTG][NUM_ELEM];
   logic [DMAG_W-1:0]  den_ff [NSTG];
   mi3_ctl_type        ctl_ff [NSTG];

   // rounding stage
   logic [QUO_W-1:0]   rq_ff  [NUM_ELEM];
   logic               rnd_ff [NUM_ELEM];
   logic               rov_ff [NUM_ELEM];
   logic               rng_ff [NUM_ELEM];
   mi3_ctl_type        rctl_ff;

   // output stage
   elem_type           quo_out_ff [NUM_ELEM];
   mi3_ctl_type        octl_ff;

   logic [NUMER_W-1:0] numer_in [NUM_ELEM];
   logic [RND_W-1:0]   mag_in   [NUM_ELEM];

   always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         numer_in[k] = NUMER_W'(in_num[k]) << (2 * FRAC_W);
         mag_in[k]   = RND_W'(rq_ff[k]) + RND_W'(rnd_ff[k]);
      end
   end

   // control travels with the data; only it is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) ctl_ff[s] <= '0;
         rctl_ff <= '0;
         octl_ff <= '0;
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int s = 1; s < NSTG; s++) ctl_ff[s] <= ctl_ff[s-1];
         rctl_ff <= ctl_ff[NSTG-1];
         octl_ff <= rctl_ff;
      end
   end

   // long division, one quotient bit per stage, MSB first
   always_ff @(posedge clock) begin
      den_ff[0] <= in_den;
      for (int k = 0; k < NUM_ELEM; k++) begin
         rem_ff[0][k] <= numer_in[k];
         quo_ff[0][k] <= '0;
         neg_ff[0][k] <= in_neg[k];
         // quotient of 2^ELEM_W or more always saturates
         ovf_ff[0][k] <= CMP_W'(numer_in[k]) >= (CMP_W'(in_den) << ELEM_W);
      end
      for (int s = 1; s < NSTG; s++) begin
         den_ff[s] <= den_ff[s-1];
         for (int k = 0; k < NUM_ELEM; k++) begin
            neg_ff[s][k] <= neg_ff[s-1][k];
            ovf_ff[s][k] <= ovf_ff[s-1][k];
            if (CMP_W'(rem_ff[s-1][k]) >= (CMP_W'(den_ff[s-1]) << (ELEM_W - s))) begin
               rem_ff[s][k] <= NUMER_W'(CMP_W'(rem_ff[s-1][k])
                                        - (CMP_W'(den_ff[s-1]) << (ELEM_W - s)));
               quo_ff[s][k] <= quo_ff[s-1][k] | (QUO_W'(1) << (ELEM_W - s));
            end else begin
               rem_ff[s][k] <= rem_ff[s-1][k];
               quo_ff[s][k] <= quo_ff[s-1][k];
            end
         end
      end
   end

   // round to nearest, ties away from zero: 2*rem >= den
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         rq_ff[k]  <= quo_ff[NSTG-1][k];
         rov_ff[k] <= ovf_ff[NSTG-1][k];
         rng_ff[k] <= neg_ff[NSTG-1][k];
         rnd_ff[k] <= (CMP_W'(rem_ff[NSTG-1][k]) << 1) >= CMP_W'(den_ff[NSTG-1]);
      end
   end

   // sign, saturate, zero out singular beats
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         priority if (rctl_ff.singular) begin
            quo_out_ff[k] <= '0;
         end else if (!rng_ff[k]) begin
            if (rov_ff[k] || mag_in[k] > LIM - RND_W'(1))
               quo_out_ff[k] <= ELEM_W'(LIM - RND_W'(1));
            else
               quo_out_ff[k] <= ELEM_W'(mag_in[k]);
         end else begin
            if (rov_ff[k] || mag_in[k] > LIM)
               quo_out_ff[k] <= ELEM_W'(~LIM + RND_W'(1));
            else
               quo_out_ff[k] <= ELEM_W'(~mag_in[k] + RND_W'(1));
         end
      end
   end

   assign out_ctl = octl_ff;
   assign out_quo = quo_out_ff;

endmodule

// ===== hw/rtl/matrix3x3_inverse.sv =====
// 3x3 fixed-point matrix inverse by adjugate, fully pipelined.
// Throughput: one matrix per clock; busy is never raised.
// Pipeline: 6 cofactor/determinant stages, 33 divider stages and 2 round/saturate
//   stages lie between a request beat and its result beat.
// Reset: synchronous; clears every valid bit, so beats in flight are dropped.
// The receiver cannot stall: rsp_valid strobes for exactly one cycle per result.
module matrix3x3_inverse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mi3_pkg::mi3_req_type req_data,
   output logic                 rsp_valid,
   output mi3_pkg::mi3_rsp_type rsp_data
);
   import mi3_pkg::*;

   localparam int LAT_EDGES = ELEM_W + 9;

   elem_type                  a_in [NUM_ELEM];

   // stage 1: products
   logic signed [PROD_W-1:0]  prod_ff [2*NUM_ELEM];
   elem_type                  row1_ff [3];
   // stage 2: cofactors
   logic signed [COF_W-1:0]   cof2_ff [NUM_ELEM];
   elem_type                  row2_ff [3];
   // stage 3: split products for the determinant
   logic signed [PART_W-1:0]  lo_ff [3];
   logic signed [PART_W-1:0]  hi_ff [3];
   logic signed [COF_W-1:0]   cof3_ff [NUM_ELEM];
   // stage 4: determinant terms
   logic signed [TERM_W-1:0]  term_ff [3];
   logic signed [COF_W-1:0]   cof4_ff [NUM_ELEM];
   // stage 5: determinant
   logic signed [DET_W-1:0]   det_ff;
   logic signed [COF_W-1:0]   cof5_ff [NUM_ELEM];
   // stage 6: magnitudes and signs into the divider
   logic [NMAG_W-1:0]         num_ff [NUM_ELEM];
   logic                      neg_ff [NUM_ELEM];
   logic [DMAG_W-1:0]         den_ff;
   logic                      sing_ff;

   logic [5:0]                vld_ff;
   mi3_ctl_type               div_ctl;
   mi3_ctl_type               out_ctl;
   elem_type                  out_quo [NUM_ELEM];

   // fully pipelined: a beat can enter every cycle
   assign busy = 1'b0;

   assign a_in[0] = req_data.a00;
   assign a_in[1] = req_data.a01;
   assign a_in[2] = req_data.a02;
   assign a_in[3] = req_data.a10;
   assign a_in[4] = req_data.a11;
   assign a_in[5] = req_data.a12;
   assign a_in[6] = req_data.a20;
   assign a_in[7] = req_data.a21;
   assign a_in[8] = req_data.a22;

   // valid bits for the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], start & ~busy};
      end
   end

   // front datapath, no reset on payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         prod_ff[2*k]   <= a_in[COF_P[k]] * a_in[COF_Q[k]];
         prod_ff[2*k+1] <= a_in[COF_S[k]] * a_in[COF_T[k]];
      end
      for (int j = 0; j < 3; j++) row1_ff[j] <= a_in[j];

      for (int k = 0; k < NUM_ELEM; k++)
         cof2_ff[k] <= COF_W'(prod_ff[2*k]) - COF_W'(prod_ff[2*k+1]);
      row2_ff <= row1_ff;

      // element times cofactor, cofactor cut into low and high halves
      for (int j = 0; j < 3; j++) begin
         lo_ff[j] <= row2_ff[j]
                     * $signed({1'b0, cof2_ff[DET_COF[j]][ELEM_W-1:0]});
         hi_ff[j] <= row2_ff[j] * $signed(cof2_ff[DET_COF[j]][COF_W-1:ELEM_W]);
      end
      cof3_ff <= cof2_ff;

      for (int j = 0; j < 3; j++)
         term_ff[j] <= (TERM_W'(hi_ff[j]) <<< ELEM_W) + TERM_W'(lo_ff[j]);
      cof4_ff <= cof3_ff;

      det_ff  <= DET_W'(term_ff[0]) + DET_W'(term_ff[1]) + DET_W'(term_ff[2]);
      cof5_ff <= cof4_ff;

      // magnitudes and result signs
      den_ff  <= DMAG_W'(det_ff[DET_W-1] ? -det_ff : det_ff);
      sing_ff <= (det_ff == '0);
      for (int k = 0; k < NUM_ELEM; k++) begin
         num_ff[k] <= NMAG_W'(cof5_ff[k][COF_W-1] ? -cof5_ff[k] : cof5_ff[k]);
         neg_ff[k] <= cof5_ff[k][COF_W-1] ^ det_ff[DET_W-1];
      end
   end

   assign div_ctl.valid    = vld_ff[5];
   assign div_ctl.singular = sing_ff;

   mi3_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (div_ctl),
      .in_num  (num_ff),
      .in_neg  (neg_ff),
      .in_den  (den_ff),
      .out_ctl (out_ctl),
      .out_quo (out_quo)
   );

   assign rsp_valid         = out_ctl.valid;
   assign rsp_data.inv00    = out_quo[0];
   assign rsp_data.inv01    = out_quo[1];
   assign rsp_data.inv02    = out_quo[2];
   assign rsp_data.inv10    = out_quo[3];
   assign rsp_data.inv11    = out_quo[4];
   assign rsp_data.inv12    = out_quo[5];
   assign rsp_data.inv20    = out_quo[6];
   assign rsp_data.inv21    = out_quo[7];
   assign rsp_data.inv22    = out_quo[8];
   assign rsp_data.singular = out_ctl.singular;

   // every result beat comes from a request beat a fixed latency earlier
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT_EDGES))
      else $error("result beat without matching request beat");

   // singular results carry all-zero elements
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.inv00 == '0 && rsp_data.inv01 == '0 && rsp_data.inv02 == '0 &&
          rsp_data.inv10 == '0 && rsp_data.inv11 == '0 && rsp_data.inv12 == '0 &&
          rsp_data.inv20 == '0 && rsp_data.inv21 == '0 && rsp_data.inv22 == '0))
      else $error("singular beat with nonzero element");

   // a nonsingular beat never reaches the divider with a zero divisor
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (div_ctl.valid && !div_ctl.singular) |-> (den_ff != '0))
      else $error("zero divisor on nonsingular beat");

endmodule
